// File: hw/rtl/mm2_pkg.sv
// ----------------------------------------------------------------------------
// mm2_pkg: shared types and constants of the MurmurHash2 engine
// Holds the hash constants, the command and status structs that pass between
// the controller and the datapath, and the register index codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mm2_pkg;

	// Hash constants. The low half of the 64-bit multiplier equals the 32-bit one.
	localparam logic [63:0] M64       = 64'hc6a4a7935bd1e995;
	localparam logic [31:0] M64_LO    = 32'h5bd1e995;
	localparam logic [31:0] M64_HI    = 32'hc6a4a793;
	localparam logic [31:0] WORD_MASK = 32'hffffffff;
	localparam int unsigned R64       = 47;
	localparam int unsigned R32       = 24;
	localparam int unsigned FIN32_A   = 13;
	localparam int unsigned FIN32_B   = 15;

	// Configuration register indexes.
	localparam logic REG_SEED = 1'b0;
	localparam logic REG_WIDE = 1'b1;

	// Kind of block held in the datapath.
	typedef enum logic [1:0] {
		CLS_ZERO,
		CLS_PART,
		CLS_FULL
	} blk_cls_t;

	// Source for the multiplier operand register.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LEN,
		OP_K,
		OP_KMIX,
		OP_H,
		OP_HFIN
	} op_sel_t;

	// Partial product step of the shared 32x32 multiplier.
	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_P0,
		MUL_P1,
		MUL_P2
	} mul_ph_t;

	// Update of the running hash.
	typedef enum logic [2:0] {
		H_NONE,
		H_SEED_LEN,
		H_SEED_P,
		H_XOR_K,
		H_XOR_P,
		H_P,
		H_P_XOR_K
	} h_sel_t;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_LEN_MUL,
		ST_SEED,
		ST_BLOCK,
		ST_K_MUL1,
		ST_K_MIX,
		ST_K_MUL2,
		ST_K_SAVE,
		ST_H_OP,
		ST_H_MUL,
		ST_H_SAVE,
		ST_FIN_CHK,
		ST_FIN_OP,
		ST_FIN_MUL,
		ST_FIN_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    idle;
		op_sel_t op_sel;
		mul_ph_t mul_ph;
		h_sel_t  h_sel;
		logic    k_from_p;
		logic    out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic     first;
		logic     last;
		logic     wide;
		blk_cls_t cls;
		logic     out_busy;
	} status_t;

endpackage

`default_nettype wire

// File: hw/rtl/mm2_if.sv
// ----------------------------------------------------------------------------
// mm2_if: stream channels of the MurmurHash2 engine
// One channel carries message blocks in, the other carries digests out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mm2_msg_if;
	logic        valid;
	logic        ready;
	logic [63:0] block_data;
	logic [3:0]  byte_count;
	logic        first_block;
	logic        last_block;
	logic [31:0] message_length;

	modport source (
		output valid, block_data, byte_count, first_block, last_block, message_length,
		input  ready
	);
	modport sink (
		input  valid, block_data, byte_count, first_block, last_block, message_length,
		output ready
	);
endinterface

interface mm2_hash_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest;

	modport source (output valid, digest, input ready);
	modport sink (input valid, digest, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/murmur2_hash_engine_core.sv
// A beat is taken only while the sequencer is idle, so a new beat cannot enter
// before the previous one has finished its walk. A first beat in 64-bit mode also
// multiplies the length by m, and a last beat runs the finalizer and waits for the
// previous digest beat to leave the output register. A 64-bit multiply by m takes
// three steps of the shared 32x32 multiplier.
// Reset clears the configuration, the open-message flag and the digest beat.
// ----------------------------------------------------------------------------
// murmur2_hash_engine_core: streaming MurmurHash2 / MurmurHash64A engine
// Holds the seed and width registers and joins the sequencer to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module murmur2_hash_engine_core
	import mm2_pkg::*;
#(
	parameter int LENGTH_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	mm2_msg_if.sink          msg,
	mm2_hash_if.source       hash,
	input  wire logic        write_en,
	input  wire logic        reg_index,
	input  wire logic [63:0] write_data
);

	logic [63:0] seed_q;
	logic        wide_q;
	logic        accept;
	cmd_t        cmd;
	status_t     status;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			wide_q <= 1'b0;
		end else if (write_en) begin
			unique case (reg_index)
				REG_SEED: seed_q <= write_data;
				REG_WIDE: wide_q <= write_data[0];
				default:  seed_q <= seed_q;
			endcase
		end
	end

	// A block beat is taken only while the sequencer is idle.
	assign msg.ready = cmd.idle;
	assign accept    = msg.valid && cmd.idle;

	mm2_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.status (status),
		.cmd    (cmd)
	);

	mm2_datapath #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.accept         (accept),
		.block_data     (msg.block_data),
		.byte_count     (msg.byte_count),
		.first_block    (msg.first_block),
		.last_block     (msg.last_block),
		.message_length (msg.message_length),
		.seed           (seed_q),
		.wide_mode      (wide_q),
		.out_take       (hash.ready),
		.out_valid      (hash.valid),
		.digest         (hash.digest)
	);

endmodule

`default_nettype wire

// File: hw/rtl/mm2_datapath.sv
// ----------------------------------------------------------------------------
// mm2_datapath: hash registers and shared multiplier
// Captures a block beat, keeps the running hash and the mixed key, and runs
// every multiply by m through one 32x32 multiplier in one or three steps.
// ----------------------------------------------------------------------------
`default_nettype none

module mm2_datapath
	import mm2_pkg::*;
#(
	parameter int LENGTH_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output status_t          status,
	input  wire logic        accept,
	input  wire logic [63:0] block_data,
	input  wire logic [3:0]  byte_count,
	input  wire logic        first_block,
	input  wire logic        last_block,
	input  wire logic [31:0] message_length,
	input  wire logic [63:0] seed,
	input  wire logic        wide_mode,
	input  wire logic        out_take,
	output logic             out_valid,
	output logic [63:0]      digest
);

	localparam int LEN_KEEP = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;
	localparam logic [31:0] LEN_MASK = WORD_MASK >> (32 - LEN_KEEP);

	logic        first_q;
	logic        last_q;
	logic        wide_q;
	blk_cls_t    cls_q;
	logic [31:0] len_q;
	logic [63:0] k_q;
	logic [63:0] h_q;
	logic [63:0] op_q;
	logic [63:0] p_q;
	logic [63:0] out_q;
	logic        out_valid_q;

	logic [63:0] k_in;
	blk_cls_t    cls_in;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic [63:0] h_val;
	logic [31:0] h32;
	logic [31:0] p32;

	assign h32 = h_q[31:0];
	assign p32 = p_q[31:0];

	// Keep only the valid bytes of the incoming block and classify it.
	always_comb begin
		k_in = '0;
		for (int i = 0; i < 8; i++) begin
			if ((4'(i) < byte_count) && (wide_mode || (i < 4))) begin
				k_in[8*i +: 8] = block_data[8*i +: 8];
			end
		end
		if (byte_count == 4'd0) begin
			cls_in = CLS_ZERO;
		end else if (byte_count >= (wide_mode ? 4'd8 : 4'd4)) begin
			cls_in = CLS_FULL;
		end else begin
			cls_in = CLS_PART;
		end
	end

	// Shared multiplier: one 32x32 product per cycle against the constant m.
	assign mul_a = (cmd.mul_ph == MUL_P1) ? op_q[63:32] : op_q[31:0];
	assign mul_b = (cmd.mul_ph == MUL_P2) ? M64_HI : M64_LO;
	assign prod  = {32'd0, mul_a} * {32'd0, mul_b};

	// Next running hash value before narrow-mode truncation.
	always_comb begin
		case (cmd.h_sel)
			H_SEED_LEN: h_val = {32'd0, seed[31:0] ^ len_q};
			H_SEED_P:   h_val = seed ^ p_q;
			H_XOR_K:    h_val = h_q ^ k_q;
			H_XOR_P:    h_val = h_q ^ p_q;
			H_P:        h_val = p_q;
			H_P_XOR_K:  h_val = p_q ^ k_q;
			default:    h_val = h_q;
		endcase
	end

	// Item capture and hash registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			first_q <= first_block;
			last_q  <= last_block;
			wide_q  <= wide_mode;
			cls_q   <= cls_in;
			len_q   <= message_length & LEN_MASK;
			k_q     <= k_in;
		end else if (cmd.k_from_p) begin
			k_q <= p_q;
		end

		h_q <= wide_q ? h_val : {32'd0, h_val[31:0]};

		case (cmd.op_sel)
			OP_LEN:  op_q <= {32'd0, len_q};
			OP_K:    op_q <= k_q;
			OP_KMIX: op_q <= wide_q ? (p_q ^ (p_q >> R64)) : {32'd0, p32 ^ (p32 >> R32)};
			OP_H:    op_q <= wide_q ? h_q : {32'd0, h32};
			OP_HFIN: op_q <= wide_q ? (h_q ^ (h_q >> R64)) : {32'd0, h32 ^ (h32 >> FIN32_A)};
			default: op_q <= op_q;
		endcase

		case (cmd.mul_ph)
			MUL_P0:  p_q <= wide_q ? prod : {32'd0, prod[31:0]};
			MUL_P1,
			MUL_P2:  p_q <= p_q + {prod[31:0], 32'd0};
			default: p_q <= p_q;
		endcase

		if (cmd.out_load) begin
			out_q <= wide_q ? (p_q ^ (p_q >> R64)) : {32'd0, p32 ^ (p32 >> FIN32_B)};
		end
	end

	// Digest beat valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign digest    = out_q;

	assign status.first    = first_q;
	assign status.last     = last_q;
	assign status.wide     = wide_q;
	assign status.cls      = cls_q;
	assign status.out_busy = out_valid_q;

endmodule

`default_nettype wire

// File: hw/rtl/mm2_ctrl.sv
// ----------------------------------------------------------------------------
// mm2_ctrl: sequencer of the MurmurHash2 engine
// Walks one block beat through seeding, key mixing, hash update and the
// finalizer, stepping the shared multiplier one partial product per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mm2_ctrl
	import mm2_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    accept,
	input  wire status_t status,
	output cmd_t         cmd
);

	state_t     state_q;
	state_t     state_d;
	logic [1:0] mphase_q;
	logic       in_msg_q;
	logic       mul_done;

	// A multiply is one step in narrow mode and three in wide mode.
	assign mul_done = !status.wide || (mphase_q == 2'd2);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_START;
			end
			ST_START: begin
				if (status.first) begin
					state_d = status.wide ? ST_LEN_MUL : ST_BLOCK;
				end else if (in_msg_q) begin
					state_d = ST_BLOCK;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_LEN_MUL: begin
				if (mul_done) state_d = ST_SEED;
			end
			ST_SEED: state_d = ST_BLOCK;
			ST_BLOCK: begin
				case (status.cls)
					CLS_FULL: state_d = ST_K_MUL1;
					CLS_PART: state_d = ST_H_OP;
					default:  state_d = ST_FIN_CHK;
				endcase
			end
			ST_K_MUL1: begin
				if (mul_done) state_d = ST_K_MIX;
			end
			ST_K_MIX: state_d = ST_K_MUL2;
			ST_K_MUL2: begin
				if (mul_done) state_d = ST_K_SAVE;
			end
			ST_K_SAVE: state_d = ST_H_OP;
			ST_H_OP:   state_d = ST_H_MUL;
			ST_H_MUL: begin
				if (mul_done) state_d = ST_H_SAVE;
			end
			ST_H_SAVE:  state_d = ST_FIN_CHK;
			ST_FIN_CHK: state_d = status.last ? ST_FIN_OP : ST_IDLE;
			ST_FIN_OP:  state_d = ST_FIN_MUL;
			ST_FIN_MUL: begin
				if (mul_done) state_d = ST_FIN_OUT;
			end
			ST_FIN_OUT: begin
				if (!status.out_busy) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd = '{idle: 1'b0, op_sel: OP_NONE, mul_ph: MUL_NONE, h_sel: H_NONE,
			k_from_p: 1'b0, out_load: 1'b0};
		unique case (state_q)
			ST_IDLE: cmd.idle = 1'b1;
			ST_START: begin
				if (status.first) begin
					if (status.wide) cmd.op_sel = OP_LEN;
					else             cmd.h_sel  = H_SEED_LEN;
				end
			end
			ST_SEED: cmd.h_sel = H_SEED_P;
			ST_BLOCK: begin
				case (status.cls)
					CLS_FULL: cmd.op_sel = OP_K;
					CLS_PART: cmd.h_sel  = H_XOR_K;
					default:  cmd.op_sel = OP_NONE;
				endcase
			end
			ST_K_MIX: cmd.op_sel = OP_KMIX;
			ST_K_SAVE: begin
				cmd.k_from_p = 1'b1;
				if (status.wide) cmd.h_sel = H_XOR_P;
			end
			ST_H_OP: cmd.op_sel = OP_H;
			ST_H_SAVE: begin
				if (!status.wide && (status.cls == CLS_FULL)) cmd.h_sel = H_P_XOR_K;
				else                                          cmd.h_sel = H_P;
			end
			ST_FIN_OP:  cmd.op_sel = OP_HFIN;
			ST_FIN_OUT: cmd.out_load = !status.out_busy;
			ST_LEN_MUL, ST_K_MUL1, ST_K_MUL2, ST_H_MUL, ST_FIN_MUL: begin
				case (mphase_q)
					2'd0:    cmd.mul_ph = MUL_P0;
					2'd1:    cmd.mul_ph = MUL_P1;
					default: cmd.mul_ph = MUL_P2;
				endcase
			end
			default: cmd.idle = 1'b0;
		endcase
	end

	// State, multiply step counter and open-message flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mphase_q <= 2'd0;
			in_msg_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.mul_ph != MUL_NONE) begin
				mphase_q <= mul_done ? 2'd0 : 2'(mphase_q + 2'd1);
			end
			if ((state_q == ST_START) && status.first) begin
				in_msg_q <= 1'b1;
			end else if (cmd.out_load) begin
				in_msg_q <= 1'b0;
			end
		end
	end

	// The digest register is only loaded once the previous digest has left.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !status.out_busy)
		else $error("digest loaded over a pending digest");

	// An accepted beat always starts its walk in the start state.
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_START))
		else $error("accepted beat did not enter start");

	// Emitting a digest closes the message.
	a_close_msg: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> !in_msg_q)
		else $error("message still open after digest");

	// The step counter is back at zero whenever the multiplier is idle.
	a_phase_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mul_ph == MUL_NONE) |-> (mphase_q == 2'd0))
		else $error("multiply step counter left running");

	// Only a wide item takes more than one multiply step.
	a_phase_wide: assert property (@(posedge clk) disable iff (!arst_n)
		(mphase_q != 2'd0) |-> status.wide)
		else $error("narrow item used a wide multiply step");

endmodule

`default_nettype wire
